// File: hw/rtl/ads_pkg.sv
package ads_pkg;

    localparam int MAX_OUT_WIDTH = 1024;
    localparam int MAX_FACTOR    = 16;
    localparam int MAX_CHANNELS  = 3;

    localparam int SAMPLE_W     = 8;
    localparam int SUM_W        = 16;
    localparam int CFG_FACTOR_W = 5;
    localparam int CFG_CHAN_W   = 2;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 2;

    localparam int LINE_DEPTH = MAX_OUT_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int DX_W       = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int FX_W       = $clog2(MAX_FACTOR);
    localparam int CP_W       = $clog2(MAX_FACTOR * MAX_OUT_WIDTH + 1);
    localparam int ROW_W      = CFG_FACTOR_W + CFG_WIDTH_W;
    localparam int AREA_W     = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int REM_W      = AREA_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
    localparam int IDX_PROD_W = DX_W + CFG_CHAN_W;
    localparam int MEAN_W     = SUM_W + 1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_WIDTH  = CFG_INDEX_W'(2);

    localparam logic [CFG_FACTOR_W-1:0] FACTOR_RESET  = CFG_FACTOR_W'(2);
    localparam logic [CFG_FACTOR_W-1:0] FACTOR_MIN    = CFG_FACTOR_W'(2);
    localparam logic [CFG_CHAN_W-1:0]   CHAN_RESET    = CFG_CHAN_W'(1);
    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET   = CFG_WIDTH_W'(1);

    // areas with a shift-based mean, ties round up
    localparam logic [AREA_W-1:0] AREA_QUAD    = AREA_W'(4);
    localparam logic [AREA_W-1:0] AREA_SIXTEEN = AREA_W'(16);
    localparam int QUAD_SHIFT    = 2;
    localparam int SIXTEEN_SHIFT = 4;
    localparam logic [MEAN_W-1:0] QUAD_BIAS    = MEAN_W'(2);
    localparam logic [MEAN_W-1:0] SIXTEEN_BIAS = MEAN_W'(8);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECALC,
        ST_READ,
        ST_ADD,
        ST_DIV,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic recalc_start;
        logic recalc_load;
        logic add;
        logic div_start;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic recalc_pending;
        logic div_busy;
        logic block_last;
        logic pow_area;
        logic out_free;
    } ctrl_sts_t;

endpackage

// File: hw/rtl/ads_ram.sv
module ads_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/ads_divider.sv
module ads_divider import ads_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [AREA_W-1:0] divisor,
    output logic [SUM_W-1:0]  quotient,
    output logic [REM_W-1:0]  remainder,
    output logic              busy
);

    logic [DIV_CNT_W-1:0] count_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [AREA_W-1:0]    divisor_reg;

    logic [REM_W:0]   rem_shift;
    logic [REM_W+1:0] diff;
    logic             fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        diff      = {1'b0, rem_shift} - (REM_W+2)'(divisor_reg);
        fits      = !diff[REM_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (start)
        begin
            count_reg <= DIV_CNT_W'(SUM_W);
        end
        else if (count_reg != '0)
        begin
            count_reg <= count_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (count_reg != '0)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? diff[REM_W-1:0] : rem_shift[REM_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = (count_reg != '0);

endmodule

// File: hw/rtl/ads_datapath.sv
module ads_datapath import ads_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [SAMPLE_W-1:0]    sample,
    input  logic                   frame_start,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_W-1:0]    out_sample,
    output logic                   row_last,
    input  ctrl_cmd_t              cmd,
    output ctrl_sts_t              sts
);

    logic [CFG_FACTOR_W-1:0] scale_factor_reg;
    logic [CFG_CHAN_W-1:0]   channel_count_reg;
    logic [CFG_WIDTH_W-1:0]  output_width_reg;
    logic                    recalc_pending_reg;

    logic [CFG_CHAN_W-1:0] chan_reg;
    logic [CP_W-1:0]       cp_reg;
    logic [DX_W-1:0]       dx_reg;
    logic [FX_W-1:0]       fx_reg;
    logic [FX_W-1:0]       band_reg;

    logic [SAMPLE_W-1:0] sample_reg;
    logic                first_reg;
    logic                last_reg;
    logic                row_end_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic [SUM_W-1:0]    sum_reg;

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic                row_last_reg;

    logic [CFG_FACTOR_W-1:0]   f_eff;
    logic [CFG_FACTOR_W-1:0]   f_last;
    logic [CFG_CHAN_W-1:0]     cn_eff;
    logic [CFG_CHAN_W-1:0]     cn_last;
    logic [CFG_WIDTH_W-1:0]    w_eff;
    logic [CFG_WIDTH_W-1:0]    w_last;
    logic [ROW_W-1:0]          row_len;
    logic [2*CFG_FACTOR_W-1:0] area_full;
    logic [AREA_W-1:0]         area;

    logic                  row_restart;
    logic [CFG_CHAN_W-1:0] chan_e;
    logic [CP_W-1:0]       cp_e;
    logic [DX_W-1:0]       dx_e;
    logic [FX_W-1:0]       fx_e;
    logic [FX_W-1:0]       band_e;
    logic                  first_e;
    logic                  last_e;
    logic                  row_end_e;
    logic [IDX_PROD_W-1:0] idx_prod;
    logic [ADDR_W-1:0]     idx_next;

    logic [CFG_CHAN_W-1:0] chan_next;
    logic [CP_W-1:0]       cp_next;
    logic [DX_W-1:0]       dx_next;
    logic [FX_W-1:0]       fx_next;
    logic [FX_W-1:0]       band_next;

    logic [SUM_W-1:0]  ram_rdata;
    logic [SUM_W-1:0]  sum_next;

    logic              div_start;
    logic [SUM_W-1:0]  div_dividend;
    logic [AREA_W-1:0] div_divisor;
    logic [SUM_W-1:0]  div_quo;
    logic [REM_W-1:0]  div_rem;
    logic              div_busy;

    logic [REM_W:0]      rem_twice;
    logic [REM_W:0]      area_ext;
    logic                round_up;
    logic [MEAN_W-1:0]   mean_wide;
    logic [SAMPLE_W-1:0] out_sample_next;

    // effective configuration
    always_comb
    begin
        if (scale_factor_reg < FACTOR_MIN)
            f_eff = FACTOR_MIN;
        else if (scale_factor_reg > CFG_FACTOR_W'(MAX_FACTOR))
            f_eff = CFG_FACTOR_W'(MAX_FACTOR);
        else
            f_eff = scale_factor_reg;

        if (channel_count_reg == '0)
            cn_eff = CFG_CHAN_W'(1);
        else if (channel_count_reg > CFG_CHAN_W'(MAX_CHANNELS))
            cn_eff = CFG_CHAN_W'(MAX_CHANNELS);
        else
            cn_eff = channel_count_reg;

        if (output_width_reg == '0)
            w_eff = CFG_WIDTH_W'(1);
        else if (output_width_reg > CFG_WIDTH_W'(MAX_OUT_WIDTH))
            w_eff = CFG_WIDTH_W'(MAX_OUT_WIDTH);
        else
            w_eff = output_width_reg;

        f_last    = f_eff - CFG_FACTOR_W'(1);
        cn_last   = cn_eff - CFG_CHAN_W'(1);
        w_last    = w_eff - CFG_WIDTH_W'(1);
        row_len   = ROW_W'(f_eff) * ROW_W'(w_eff);
        area_full = (2*CFG_FACTOR_W)'(f_eff) * (2*CFG_FACTOR_W)'(f_eff);
        area      = AREA_W'(area_full);
    end

    // position of the incoming sample, then the position after it
    always_comb
    begin
        row_restart = frame_start || (ROW_W'(cp_reg) >= row_len);
        chan_e = (frame_start || chan_reg >= cn_eff) ? '0 : chan_reg;
        cp_e   = row_restart ? '0 : cp_reg;
        dx_e   = row_restart ? '0 : dx_reg;
        fx_e   = row_restart ? '0 : fx_reg;
        band_e = (frame_start || CFG_FACTOR_W'(band_reg) >= f_eff) ? '0 : band_reg;

        first_e   = (band_e == '0) && (fx_e == '0);
        last_e    = (CFG_FACTOR_W'(band_e) == f_last) && (CFG_FACTOR_W'(fx_e) == f_last);
        row_end_e = (CFG_WIDTH_W'(dx_e) == w_last) && (chan_e == cn_last);

        idx_prod = IDX_PROD_W'(dx_e) * IDX_PROD_W'(cn_eff);
        idx_next = ADDR_W'(idx_prod) + ADDR_W'(chan_e);

        chan_next = chan_e;
        cp_next   = cp_e;
        dx_next   = dx_e;
        fx_next   = fx_e;
        band_next = band_e;
        if (chan_e == cn_last)
        begin
            chan_next = '0;
            if (ROW_W'(cp_e) == row_len - ROW_W'(1))
            begin
                cp_next   = '0;
                dx_next   = '0;
                fx_next   = '0;
                band_next = (CFG_FACTOR_W'(band_e) == f_last) ? '0 : band_e + FX_W'(1);
            end
            else
            begin
                cp_next = cp_e + CP_W'(1);
                if (CFG_FACTOR_W'(fx_e) == f_last)
                begin
                    fx_next = '0;
                    dx_next = dx_e + DX_W'(1);
                end
                else
                begin
                    fx_next = fx_e + FX_W'(1);
                end
            end
        end
        else
        begin
            chan_next = chan_e + CFG_CHAN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg  <= FACTOR_RESET;
            channel_count_reg <= CHAN_RESET;
            output_width_reg  <= WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE_FACTOR:  scale_factor_reg  <= cfg_data[CFG_FACTOR_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CFG_CHAN_W-1:0];
                REG_OUTPUT_WIDTH:  output_width_reg  <= cfg_data[CFG_WIDTH_W-1:0];
                default:           ;
            endcase
        end
    end

    // a config change re-derives block column and offset from the column count;
    // a write during a pass asks for another one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recalc_pending_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            recalc_pending_reg <= 1'b1;
        end
        else if (cmd.recalc_start)
        begin
            recalc_pending_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
            cp_reg   <= '0;
            dx_reg   <= '0;
            fx_reg   <= '0;
            band_reg <= '0;
        end
        else if (cmd.accept)
        begin
            chan_reg <= chan_next;
            cp_reg   <= cp_next;
            dx_reg   <= dx_next;
            fx_reg   <= fx_next;
            band_reg <= band_next;
        end
        else if (cmd.recalc_load)
        begin
            dx_reg <= DX_W'(div_quo);
            fx_reg <= FX_W'(div_rem);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg  <= sample;
            first_reg   <= first_e;
            last_reg    <= last_e;
            row_end_reg <= row_end_e;
            idx_reg     <= idx_next;
        end
        if (cmd.add)
        begin
            sum_reg <= sum_next;
        end
    end

    // first sample of a block overwrites the stale entry
    assign sum_next = first_reg ? SUM_W'(sample_reg) : ram_rdata + SUM_W'(sample_reg);

    ads_ram #(
        .WIDTH (SUM_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (cmd.add),
        .waddr (idx_reg),
        .wdata (sum_next),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign div_start    = cmd.div_start || cmd.recalc_start;
    assign div_dividend = cmd.recalc_start ? SUM_W'(cp_reg) : sum_next;
    assign div_divisor  = cmd.recalc_start ? AREA_W'(f_eff) : area;

    ads_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .busy      (div_busy)
    );

    // mean with rounding: shift for the two fixed areas, nearest-even otherwise
    always_comb
    begin
        rem_twice = {div_rem, 1'b0};
        area_ext  = (REM_W+1)'(area);
        round_up  = (rem_twice > area_ext) || ((rem_twice == area_ext) && div_quo[0]);
        if (area == AREA_QUAD)
            mean_wide = (MEAN_W'(sum_reg) + QUAD_BIAS) >> QUAD_SHIFT;
        else if (area == AREA_SIXTEEN)
            mean_wide = (MEAN_W'(sum_reg) + SIXTEEN_BIAS) >> SIXTEEN_SHIFT;
        else
            mean_wide = MEAN_W'(div_quo) + MEAN_W'(round_up);
        out_sample_next = (mean_wide > MEAN_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                             : SAMPLE_W'(mean_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_sample_reg <= out_sample_next;
            row_last_reg   <= row_end_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign row_last   = row_last_reg;

    always_comb
    begin
        sts.recalc_pending = recalc_pending_reg;
        sts.div_busy       = div_busy;
        sts.block_last     = last_reg;
        sts.pow_area       = (area == AREA_QUAD) || (area == AREA_SIXTEEN);
        sts.out_free       = !out_valid_reg || out_ready;
    end

    a_out_rise_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("result appeared without a load");

    a_chan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (chan_reg < $past(cn_eff)))
        else $error("channel position left its range");

endmodule

// File: hw/rtl/ads_ctrl.sv
module ads_ctrl import ads_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output ctrl_cmd_t cmd,
    input  ctrl_sts_t sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sts.recalc_pending)
                    state_next = ST_RECALC;
                else if (in_valid)
                    state_next = ST_READ;
            end
            ST_RECALC:
            begin
                if (!sts.div_busy)
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (!sts.block_last)
                    state_next = ST_IDLE;
                else if (sts.pow_area)
                    state_next = ST_RESULT;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready         = !sts.recalc_pending;
                cmd.accept       = !sts.recalc_pending && in_valid;
                cmd.recalc_start = sts.recalc_pending;
            end
            ST_RECALC:
            begin
                cmd.recalc_load = !sts.div_busy;
            end
            ST_ADD:
            begin
                cmd.add       = 1'b1;
                cmd.div_start = sts.block_last && !sts.pow_area;
            end
            ST_RESULT:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_READ))
        else $error("transfer not followed by line read");

    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> sts.div_busy)
        else $error("divider did not start");

    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sts.div_busy)
        else $error("input ready while divider busy");

endmodule

// File: hw/rtl/area_downscale_integer_factor.sv
// Integer-factor box downscaler for 8-bit samples, 1 to 3 interleaved channels.
// Input channel (in_valid/in_ready): one sample per transfer in raster order,
// with frame_start on the first sample of a frame. Output channel
// (out_valid/out_ready): one rounded block mean per factor x factor block and
// channel, row_last on the final sample of an output row.
// Config port: cfg_we/cfg_index/cfg_data, index 0 factor, 1 channels, 2 width.
// Steps per input transfer when no block completes: accept, line read, line
// update. A completing block adds a result step for areas 4 and 16, and
// otherwise a division by the 16-step bit-serial divider before that step.
// After a config write the divider re-derives the block position; the input
// is held off during that pass, and a write during it starts another.
// Reset: position counters clear; the sum line is not cleared, the first
// sample of every block overwrites its entry.
// The result sits in an output register; the next input is taken while it
// waits. A stalled receiver holds the block only when a second result is due.
module area_downscale_integer_factor import ads_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_W-1:0]    sample,
    input  logic                   frame_start,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_W-1:0]    out_sample,
    output logic                   row_last,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    ads_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ads_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_sample  (out_sample),
        .row_last    (row_last),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// File: tb/downscale_checker.sv
module downscale_checker import ads_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [SAMPLE_W-1:0]    sample,
    input  logic                   frame_start,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [SAMPLE_W-1:0]    out_sample,
    input  logic                   row_last,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     error_count,
    output int                     pending_means
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean;
        logic                row_end;
    } block_mean_t;

    logic [CFG_FACTOR_W-1:0] factor_reg;
    logic [CFG_CHAN_W-1:0]   chan_reg;
    logic [CFG_WIDTH_W-1:0]  width_reg;

    // running block sums, one entry per output sample of a row
    logic [SUM_W-1:0] sum_line [LINE_DEPTH];
    int unsigned      src_col;
    int unsigned      band_row;
    int unsigned      chan_idx;

    block_mean_t expected_means [$];
    int          mismatches = 0;

    function automatic logic [SAMPLE_W-1:0] rounded_mean(input int unsigned total,
                                                         input int unsigned area);
        int unsigned q;
        int unsigned r;
        if (area == AREA_QUAD) begin
            q = (total + QUAD_BIAS) >> QUAD_SHIFT;
        end
        else if (area == AREA_SIXTEEN) begin
            q = (total + SIXTEEN_BIAS) >> SIXTEEN_SHIFT;
        end
        else begin
            // nearest, ties to even
            q = total / area;
            r = total % area;
            if (2 * r > area || (2 * r == area && (q % 2) != 0))
                q++;
        end
        if (q > SAMPLE_MAX)
            q = SAMPLE_MAX;
        return SAMPLE_W'(q);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    task automatic take_sample(input logic [SAMPLE_W-1:0] s, input logic fs);
        int unsigned      f;
        int unsigned      cn;
        int unsigned      w;
        int unsigned      col_blk;
        int unsigned      col_in;
        int unsigned      idx;
        logic [SUM_W-1:0] acc;
        block_mean_t      res;
        f = factor_reg;
        if (f < FACTOR_MIN)
            f = FACTOR_MIN;
        if (f > MAX_FACTOR)
            f = MAX_FACTOR;
        cn = chan_reg;
        if (cn < 1)
            cn = 1;
        if (cn > MAX_CHANNELS)
            cn = MAX_CHANNELS;
        w = width_reg;
        if (w < 1)
            w = 1;
        if (w > MAX_OUT_WIDTH)
            w = MAX_OUT_WIDTH;

        if (fs) begin
            src_col  = 0;
            band_row = 0;
            chan_idx = 0;
        end
        // counters may sit outside the row after a register change
        if (chan_idx >= cn)
            chan_idx = 0;
        if (src_col >= f * w)
            src_col = 0;
        if (band_row >= f)
            band_row = 0;

        col_blk = src_col / f;
        col_in  = src_col % f;
        idx     = col_blk * cn + chan_idx;
        if (idx >= LINE_DEPTH)
            idx = 0;

        // first sample of a block overwrites its entry
        if (band_row == 0 && col_in == 0)
            acc = SUM_W'(s);
        else
            acc = sum_line[idx] + SUM_W'(s);
        sum_line[idx] = acc;

        if (band_row == f - 1 && col_in == f - 1) begin
            res.mean    = rounded_mean(acc, f * f);
            res.row_end = (col_blk == w - 1 && chan_idx == cn - 1);
            expected_means.push_back(res);
        end

        chan_idx++;
        if (chan_idx >= cn) begin
            chan_idx = 0;
            src_col++;
            if (src_col >= f * w) begin
                src_col = 0;
                band_row++;
                if (band_row >= f)
                    band_row = 0;
            end
        end
    endtask

    task automatic check_mean();
        block_mean_t want;
        if (expected_means.size() == 0) begin
            report_mismatch($sformatf("result %0d row_last %0b with none expected",
                                      out_sample, row_last));
            return;
        end
        want = expected_means.pop_front();
        if (out_sample !== want.mean)
            report_mismatch($sformatf("out_sample %0d, expected %0d", out_sample, want.mean));
        if (row_last !== want.row_end)
            report_mismatch($sformatf("row_last %0b, expected %0b (out_sample %0d)",
                                      row_last, want.row_end, want.mean));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            factor_reg = FACTOR_RESET;
            chan_reg   = CHAN_RESET;
            width_reg  = WIDTH_RESET;
            src_col    = 0;
            band_row   = 0;
            chan_idx   = 0;
            expected_means.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SCALE_FACTOR:  factor_reg = cfg_data[CFG_FACTOR_W-1:0];
                    REG_CHANNEL_COUNT: chan_reg   = cfg_data[CFG_CHAN_W-1:0];
                    REG_OUTPUT_WIDTH:  width_reg  = cfg_data[CFG_WIDTH_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                take_sample(sample, frame_start);
            if (out_valid && out_ready)
                check_mean();
        end
        error_count   <= mismatches;
        pending_means <= expected_means.size();
    end

endmodule

// File: tb/tb.sv
module tb;
    import ads_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES  = 1000000;

    typedef enum {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [SAMPLE_W-1:0]    sample;
    logic                   frame_start;
    logic                   out_valid;
    logic                   out_ready;
    logic [SAMPLE_W-1:0]    out_sample;
    logic                   row_last;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int error_count;
    int pending_means;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_len;
    int hold_seq;

    area_downscale_integer_factor u_top (.*);

    downscale_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver side; a long hold-off is counted down here
    initial
    begin : receiver_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left != 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(2))
            0:       return SAMPLE_W'($urandom_range(3));
            1:       return $urandom_range(1) ? SAMPLE_MAX : '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SEND: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            IDLE_BOTH: begin send_idle_pct = 24; recv_stall_pct = 24; end
            default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // returns after an edge at which in_ready reads high
    task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input logic fs);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= s;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic stop_offering();
        in_valid <= 1'b0;
    endtask

    // first edge lets the checker count the last transfer
    task automatic drain();
        @(posedge clk);
        while (pending_means != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input int f_raw, input int c_raw, input int w_raw);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SCALE_FACTOR;
        cfg_data  <= CFG_DATA_W'(f_raw);
        @(posedge clk);
        cfg_index <= REG_CHANNEL_COUNT;
        cfg_data  <= CFG_DATA_W'(c_raw);
        @(posedge clk);
        cfg_index <= REG_OUTPUT_WIDTH;
        cfg_data  <= CFG_DATA_W'(w_raw);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // fresh: open with a frame start; noise: occasional restart mid-frame
    task automatic run_phase(input int f_raw, input int c_raw, input int w_raw,
                             input int n_items, input idle_mode_t mode,
                             input bit fresh, input bit noise, input int hold_cycles);
        int f_eff;
        int c_eff;
        int w_eff;
        int band_len;
        int frame_len;
        int pos;
        bit fs;
        drain();
        write_regs(f_raw, c_raw, w_raw);
        set_idling(mode);
        f_eff = (f_raw < int'(FACTOR_MIN)) ? int'(FACTOR_MIN) :
                (f_raw > MAX_FACTOR) ? MAX_FACTOR : f_raw;
        c_eff = (c_raw == 0) ? 1 : c_raw;
        w_eff = (w_raw == 0) ? 1 : (w_raw > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : w_raw;
        band_len  = f_eff * f_eff * w_eff * c_eff;
        frame_len = band_len * $urandom_range(1, 3);
        pos = fresh ? 0 : 1;
        if (hold_cycles != 0) begin
            hold_len = hold_cycles;
            hold_seq++;
        end
        for (int i = 0; i < n_items; i++) begin
            fs = (pos == 0) || (noise && i != 0 && $urandom_range(199) == 0);
            if (fs) begin
                pos       = 0;
                frame_len = band_len * $urandom_range(1, 3);
            end
            offer_sample(pick_sample(), fs);
            pos = (pos + 1 >= frame_len) ? 0 : pos + 1;
        end
        stop_offering();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample         = '0;
        frame_start    = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_SCALE_FACTOR;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 0;
        hold_seq       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 2x2 blocks, one channel, one output pixel per row
        offer_sample(SAMPLE_MAX, 1'b1);
        offer_sample(SAMPLE_MAX, 1'b0);
        offer_sample(SAMPLE_MAX, 1'b0);
        offer_sample(SAMPLE_MAX, 1'b0);
        // tie, rounds up
        offer_sample(8'd0, 1'b0);
        offer_sample(8'd1, 1'b0);
        offer_sample(8'd0, 1'b0);
        offer_sample(8'd1, 1'b0);
        // frame restart inside a block
        offer_sample(8'd9, 1'b0);
        offer_sample(8'd200, 1'b1);
        offer_sample(8'd0, 1'b0);
        offer_sample(8'd0, 1'b0);
        offer_sample(8'd3, 1'b0);
        stop_offering();
        drain();
        // all registers zero: used as the minimum settings
        write_regs(0, 0, 0);
        offer_sample(8'd1, 1'b1);
        offer_sample(8'd1, 1'b0);
        offer_sample(8'd1, 1'b0);
        offer_sample(8'd0, 1'b0);
        stop_offering();

        run_phase(2, 3, 4, 100, IDLE_NONE, 1'b1, 1'b1, 400);
        run_phase(3, 1, 5, 80, IDLE_SEND, 1'b1, 1'b1, 0);
        run_phase(4, 2, 3, 100, IDLE_RECV, 1'b1, 1'b1, 0);
        run_phase(5, 1, 2, 60, IDLE_BOTH, 1'b1, 1'b1, 0);
        run_phase(6, 1, 1, 80, IDLE_NONE, 1'b1, 1'b1, 0);
        run_phase(8, 3, 1, 200, IDLE_RECV, 1'b1, 1'b1, 0);
        // factor above range, area 256
        run_phase(31, 1, 1, 260, IDLE_SEND, 1'b1, 1'b0, 0);
        // factor below range with the widest row: start of the first band
        run_phase(1, 1, 2047, 40, IDLE_NONE, 1'b1, 1'b0, 0);
        // stop at band row 3, column 7, channel 1, then shrink every register
        // without a frame start so all counters wrap
        run_phase(4, 3, 3, 130, IDLE_BOTH, 1'b1, 1'b0, 0);
        run_phase(2, 1, 2, 60, IDLE_RECV, 1'b0, 1'b1, 0);
        repeat (4) begin
            run_phase($urandom_range(2, 7), $urandom_range(1, 3), $urandom_range(1, 6),
                      35, idle_mode_t'($urandom_range(3)), 1'b1, 1'b1, 0);
        end

        drain();
        if (error_count == 0 && pending_means == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
